>>> rtl/brsc_pkg.sv
// Package for the bitmap range set/clear/test block: constants, codes and types.
package brsc_pkg;

    localparam int MAX_WORDS = 128;
    localparam int WORD_W    = 64;
    localparam int OFF_W     = 6;
    localparam int WIDX_W    = $clog2(MAX_WORDS);
    localparam int FLD_W     = 16;
    localparam int END_W     = FLD_W + 1;
    localparam int CFG_W     = 8;
    localparam int CFG_RESET = 128;
    localparam int Q_DEPTH   = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_RANGE = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic              imm;
        t_status           status;
        t_op               op;
        logic [WIDX_W-1:0] first;
        logic [WIDX_W-1:0] last;
        logic [OFF_W-1:0]  head_off;
        logic [OFF_W-1:0]  end_off;
    } t_cmd;

endpackage

>>> rtl/bitmap_range_set_clear_test.sv
// Top level of the allocation bitmap range test/set/clear block.
// Usage:
//   s_axis carries one request word: op, start bit and bit count. m_axis
//   returns exactly one status word per request, in request order.
//   i_cfg_we/i_cfg_wdata write the number of 64-bit bitmap words in use;
//   write it only while no request is in flight.
// Flow:
//   A request enters a two-entry queue in the accept cycle. A request with
//   zero count, op three or an out-of-range span is answered without a
//   bitmap access. A range over N words first issues the read of the first
//   word, then does one read-modify-write per word, set by the single read and
//   single write port of the bitmap RAM. A test stops at the first word
//   with a set bit. The status follows in the cycle after the back end ends.
// Reset:
//   The bitmap reads as all zero (per-word valid flags are cleared), the
//   size register returns to 128 words and the queue empties. No clearing
//   pass is needed.
// Stalls:
//   A held result blocks the back end; the queue keeps taking requests
//   until it is full, then s_axis tready drops.
module bitmap_range_set_clear_test (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [brsc_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [1:0] op, [17:2] start, [33:18] count, [39:34] zero
    input  logic [brsc_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // [1:0] status, [7:2] zero
    output logic [brsc_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata
);
    import brsc_pkg::*;

    t_cmd       dec_cmd;
    t_cmd       q_cmd;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic       push;
    logic [1:0] status;

    assign o_s_axis_tready = !q_full;
    assign push            = i_s_axis_tvalid && !q_full;

    brsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_axis_tdata[1:0]),
        .i_start     (i_s_axis_tdata[2 +: FLD_W]),
        .i_count     (i_s_axis_tdata[2 + FLD_W +: FLD_W]),
        .o_cmd       (dec_cmd)
    );

    brsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (dec_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    brsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_status (status)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - 2)'(0), status};
endmodule

>>> rtl/brsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/brsc_front.sv
// Front end: size register, request decode and range check.
module brsc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [brsc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [1:0]                     i_op,
    input  logic [brsc_pkg::FLD_W-1:0]     i_start,
    input  logic [brsc_pkg::FLD_W-1:0]     i_count,
    output brsc_pkg::t_cmd                 o_cmd
);
    import brsc_pkg::*;

    logic [CFG_W-1:0] r_words_in_use;
    logic [END_W-1:0] cfg_words;
    logic [END_W-1:0] eff_words;
    logic [END_W-1:0] total;
    logic [END_W-1:0] end_bit;
    logic [END_W-1:0] end_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_in_use <= CFG_W'(CFG_RESET);
        end else if (i_cfg_we) begin
            r_words_in_use <= i_cfg_wdata;
        end
    end

    always_comb begin
        cfg_words = END_W'(r_words_in_use);
        eff_words = (cfg_words > END_W'(MAX_WORDS)) ? END_W'(MAX_WORDS) : cfg_words;
        total     = eff_words << OFF_W;
        end_bit   = END_W'(i_start) + END_W'(i_count);
        end_m1    = end_bit - END_W'(1);

        o_cmd.imm       = 1'b0;
        o_cmd.status    = ST_OK;
        o_cmd.op        = t_op'(i_op);
        o_cmd.first     = WIDX_W'(i_start >> OFF_W);
        o_cmd.last      = WIDX_W'(end_m1 >> OFF_W);
        o_cmd.head_off  = i_start[OFF_W-1:0];
        o_cmd.end_off   = end_bit[OFF_W-1:0];

        if (t_op'(i_op) == OP_NONE || i_count == '0) begin
            o_cmd.imm = 1'b1;
        end else if (END_W'(i_start) >= total || end_bit > total) begin
            o_cmd.imm    = 1'b1;
            o_cmd.status = ST_RANGE;
        end
    end
endmodule

>>> rtl/brsc_queue.sv
// Short show-ahead queue of decoded requests between front and back.
module brsc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  brsc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output brsc_pkg::t_cmd o_cmd
);
    import brsc_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
endmodule

>>> rtl/brsc_back.sv
// Back end: word-by-word read-modify-write over the bitmap and result register.
module brsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  brsc_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [1:0]     o_out_status
);
    import brsc_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [WIDX_W-1:0] r_w;
    logic [WIDX_W-1:0] n_w;
    logic              r_out_valid;
    logic              n_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [MAX_WORDS-1:0] r_vld;
    logic              r_rd_vld;

    logic              slot_free;
    logic              load;
    t_status           load_status;
    logic              we;
    logic [WIDX_W-1:0] raddr;
    logic [WORD_W-1:0] rdata;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] wdata;
    logic              is_last;

    brsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_w),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign cur       = r_rd_vld ? rdata : '0;
    assign is_last   = (r_w == r_cmd.last);

    always_comb begin
        mask = '1;
        if (r_w == r_cmd.first) begin
            mask = mask & ({WORD_W{1'b1}} << r_cmd.head_off);
        end
        if (is_last && r_cmd.end_off != '0) begin
            mask = mask & (({{(WORD_W-1){1'b0}}, 1'b1} << r_cmd.end_off) - WORD_W'(1));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && slot_free && !i_q_cmd.imm) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (is_last || (r_cmd.op == OP_TEST && (cur & mask) != '0)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop     = 1'b0;
        load        = 1'b0;
        load_status = ST_OK;
        we          = 1'b0;
        wdata       = cur | mask;
        raddr       = i_q_cmd.first;
        n_cmd       = r_cmd;
        n_w         = r_w;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.imm) begin
                        load        = 1'b1;
                        load_status = i_q_cmd.status;
                    end else begin
                        n_cmd = i_q_cmd;
                        n_w   = i_q_cmd.first;
                    end
                end
            end
            S_RUN: begin
                raddr = r_w + WIDX_W'(1);
                n_w   = r_w + WIDX_W'(1);
                case (r_cmd.op)
                    OP_TEST: begin
                        if ((cur & mask) != '0) begin
                            load        = 1'b1;
                            load_status = ST_BUSY;
                        end else if (is_last) begin
                            load = 1'b1;
                        end
                    end
                    OP_SET: begin
                        we    = 1'b1;
                        wdata = cur | mask;
                        load  = is_last;
                    end
                    default: begin
                        we    = 1'b1;
                        wdata = cur & ~mask;
                        load  = is_last;
                    end
                endcase
            end
            default: ;
        endcase
        n_out_valid = load || (r_out_valid && !i_out_ready);
        n_status    = load ? load_status : r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (we) begin
                r_vld[r_w] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_w      <= n_w;
        r_status <= n_status;
        r_rd_vld <= r_vld[raddr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_status;
endmodule

>>> tb/sv/tb.sv
// Self-checking bench for the bitmap range test/set/clear block over stream ports.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brsc_pkg::*;

    typedef struct {
        t_status     status;
        t_op         op;
        logic [15:0] start;
        logic [15:0] count;
    } t_pending;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    t_pending    status_q[$];
    logic [63:0] bitmap_model [MAX_WORDS];
    logic [7:0]  words_model;
    int          mismatches = 0;
    int          send_idle = 37;
    int          recv_idle = 78;
    int          hold_cycles = 0;
    logic        hold_tok = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    bitmap_range_set_clear_test DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50) $display("ERROR %0t: %s", $realtime, msg);
    endtask

    function automatic t_status predict_status(input t_op op, input logic [15:0] start,
                                               input logic [15:0] count);
        int unsigned total, stop, first, last;
        logic [63:0] mask;
        total = 32'((words_model > 8'(MAX_WORDS)) ? 8'(MAX_WORDS) : words_model) * 32'd64;
        if (op == OP_NONE || count == 0) return ST_OK;
        stop = 32'(start) + 32'(count);
        if (start >= total || stop > total) return ST_RANGE;
        first = 32'(start >> 6);
        last  = (stop - 1) >> 6;
        for (int unsigned w = first; w <= last; w++) begin
            mask = {64{1'b1}};
            if (w == first) mask &= {64{1'b1}} << start[5:0];
            if (w == last && stop[5:0] != 0) mask &= (64'd1 << stop[5:0]) - 64'd1;
            case (op)
                OP_TEST: begin
                    if ((bitmap_model[w] & mask) != 64'd0) return ST_BUSY;
                end
                OP_SET: begin
                    bitmap_model[w] |= mask;
                end
                default: begin
                    bitmap_model[w] &= ~mask;
                end
            endcase
        end
        return ST_OK;
    endfunction

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_tok != hold_seen) begin
            hold_seen       <= hold_tok;
            hold_left       <= hold_cycles;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_pending exp_item;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (status_q.size() == 0) begin
                report_mismatch("status word with no request pending");
            end else begin
                exp_item = status_q.pop_front();
                if (o_m_axis_tdata[1:0] !== exp_item.status)
                    report_mismatch($sformatf("op %s start %0d count %0d: status %0d, want %0d",
                                              exp_item.op.name(), exp_item.start,
                                              exp_item.count, o_m_axis_tdata[1:0],
                                              exp_item.status));
            end
        end
    end

    task automatic send_word(input t_op op, input logic [15:0] start,
                             input logic [15:0] count);
        t_pending item;
        while ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'd0, count, start, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        item.op     = op;
        item.start  = start;
        item.count  = count;
        item.status = predict_status(op, start, count);
        status_q.push_back(item);
    endtask

    task automatic wait_idle(input int margin);
        i_s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (margin) @(posedge i_clk);
    endtask

    task automatic set_words(input logic [7:0] words);
        wait_idle(4);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= words;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        words_model = words;
    endtask

    task automatic test_directed();
        send_word(OP_TEST,  16'd0,     16'd1);
        send_word(OP_SET,   16'd0,     16'd1);
        send_word(OP_TEST,  16'd0,     16'd1);
        send_word(OP_TEST,  16'd0,     16'd0);
        send_word(OP_SET,   16'd60,    16'd8);
        send_word(OP_TEST,  16'd63,    16'd1);
        send_word(OP_CLEAR, 16'd60,    16'd8);
        send_word(OP_TEST,  16'd60,    16'd8);
        // range ending on a word boundary: last word must be covered
        send_word(OP_SET,   16'd64,    16'd64);
        send_word(OP_TEST,  16'd127,   16'd1);
        send_word(OP_TEST,  16'd128,   16'd1);
        send_word(OP_SET,   16'd8191,  16'd1);
        send_word(OP_TEST,  16'd8191,  16'd1);
        send_word(OP_TEST,  16'd8192,  16'd1);
        send_word(OP_TEST,  16'd8190,  16'd3);
        send_word(OP_NONE,  16'd200,   16'd5);
        send_word(OP_TEST,  16'd200,   16'd5);
        send_word(OP_CLEAR, 16'd0,     16'd8192);
        send_word(OP_TEST,  16'd0,     16'd8192);
        send_word(OP_SET,   16'd65535, 16'd65535);
        send_word(OP_TEST,  16'd0,     16'd65535);
        set_words(8'd0);
        send_word(OP_TEST,  16'd0,     16'd1);
        send_word(OP_SET,   16'd0,     16'd0);
        // above the array size counts as full size
        set_words(8'd255);
        send_word(OP_SET,   16'd0,     16'd8192);
        send_word(OP_TEST,  16'd8191,  16'd1);
        send_word(OP_CLEAR, 16'd0,     16'd8192);
        set_words(8'd1);
        send_word(OP_TEST,  16'd0,     16'd64);
        send_word(OP_TEST,  16'd0,     16'd65);
    endtask

    task automatic test_random_ranges(input logic [7:0] words, input int n);
        int unsigned span, cap, sel, pick, st, cnt;
        t_op op;
        set_words(words);
        span = 32'((words > 8'(MAX_WORDS)) ? 8'(MAX_WORDS) : words) * 32'd64;
        cap  = (span < 200) ? span : 200;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            op = (pick < 40) ? OP_TEST : (pick < 70) ? OP_SET : (pick < 95) ? OP_CLEAR : OP_NONE;
            sel = $urandom_range(99);
            if (sel < 70 && span != 0) begin
                cnt = ($urandom_range(19) == 0) ? $urandom_range(span, 1)
                                                : $urandom_range(cap, 1);
                st  = $urandom_range(span - cnt, 0);
                if ($urandom_range(3) == 0) st = st & ~32'd63;
                if ($urandom_range(3) == 0) cnt = ((st + cnt + 63) & ~32'd63) - st;
            end else if (sel < 80) begin
                cnt = 0;
                st  = $urandom_range(65535);
            end else if (sel < 90 && span != 0) begin
                cnt = $urandom_range(100, 1);
                st  = span - cnt + $urandom_range(cnt, 1);
            end else begin
                cnt = $urandom_range(65535);
                st  = $urandom_range(65535);
            end
            send_word(op, st[15:0], cnt[15:0]);
        end
    endtask

    task automatic test_backpressure();
        int unsigned st;
        set_words(8'd128);
        hold_cycles = 300;
        hold_tok    = ~hold_tok;
        for (int i = 0; i < 12; i++) begin
            st = $urandom_range(8000);
            send_word((i % 2 == 0) ? OP_SET : OP_TEST, st[15:0],
                      16'($urandom_range(190, 1)));
        end
        wait_idle(4);
    endtask

    initial begin
        for (int w = 0; w < MAX_WORDS; w++) bitmap_model[w] = '0;
        words_model = 8'(CFG_RESET);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 37;
        recv_idle = 78;
        test_directed();
        test_random_ranges(8'd128, 350);
        test_random_ranges(8'd1, 120);
        test_random_ranges(8'd255, 200);

        send_idle = 78;
        recv_idle = 37;
        test_random_ranges(8'd2, 120);
        test_random_ranges(8'd0, 40);
        test_random_ranges(8'd37, 200);

        send_idle = 0;
        recv_idle = 0;
        test_backpressure();
        test_random_ranges(8'd129, 250);
        test_random_ranges(8'd128, 170);

        wait_idle(150);
        if (mismatches == 0 && status_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
rtl/brsc_pkg.sv
rtl/brsc_ram.sv
rtl/brsc_front.sv
rtl/brsc_queue.sv
rtl/brsc_back.sv
rtl/bitmap_range_set_clear_test.sv
tb/sv/tb.sv
